>>> rtl/core/imh_pkg.sv
// Shared types, constants and codes of the indexed min-heap block.
package imh_pkg;

   localparam int HEAP_DEPTH_DEF   = 1024;
   localparam int MAX_REQUESTS_DEF = 4096;
   localparam int KEY_W            = 64;

   localparam logic [1:0] FUNC_INSERT   = 2'd0;
   localparam logic [1:0] FUNC_GET_MIN  = 2'd1;
   localparam logic [1:0] FUNC_EXTRACT  = 2'd2;
   localparam logic [1:0] FUNC_DECREASE = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_BAD_REQ   = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;

   localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]        func;
      logic signed [63:0] key_value;
      logic [11:0]       request_id;
      logic [62:0]       delta;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] min_value;
      logic              min_valid;
      logic [2:0]        status;
   } rsp_word_type;

endpackage

>>> rtl/core/imh_alu.sv
// Shared subtract unit: unsigned less-than and saturating difference of biased keys.
module imh_alu (
   input  logic [imh_pkg::KEY_W-1:0] a,
   input  logic [imh_pkg::KEY_W-1:0] b,
   output logic                      lt,
   output logic [imh_pkg::KEY_W-1:0] sat_diff
);
   import imh_pkg::*;

   logic [KEY_W:0] diff;

   assign diff     = {1'b0, a} - {1'b0, b};
   assign lt       = diff[KEY_W];
   assign sat_diff = diff[KEY_W] ? '0 : diff[KEY_W-1:0];

endmodule

>>> rtl/core/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key: sequencer, heap and request memories.
// Insert and decrease-key climb one level per S_UP/S_UP_CMP pair; extract-min sinks one level
// per pass through S_DN, S_DN_L, S_DN_R (when a right child exists) and S_DN_SEL.
// One word at a time: req_stall holds new words until the current word's result is registered;
// the sift loop through the memories sets the pace, and a stalled result holds the next accept.
// Reset clears the heap count, the request count and the handshake; memories hold
// undefined contents until written and need no clearing pass.
module indexed_min_heap_decrease_key #(
   parameter int HEAP_DEPTH   = imh_pkg::HEAP_DEPTH_DEF,
   parameter int MAX_REQUESTS = imh_pkg::MAX_REQUESTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  imh_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output imh_pkg::rsp_word_type rsp_word
);
   import imh_pkg::*;

   localparam int AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int SW  = $clog2(HEAP_DEPTH + 1);
   localparam int RW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int RCW = $clog2(MAX_REQUESTS + 1);
   localparam int CW  = (RCW > 12) ? RCW : 12;
   localparam int LW  = AW + 2;

   localparam logic [SW-1:0]  NO_SLOT  = SW'(HEAP_DEPTH);
   localparam logic [RCW-1:0] REQ_MAX  = RCW'(MAX_REQUESTS);
   localparam logic [SW-1:0]  HEAP_MAX = SW'(HEAP_DEPTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EX_OWN  = 4'd1;
   localparam logic [3:0] S_EX_LAST = 4'd2;
   localparam logic [3:0] S_GM      = 4'd3;
   localparam logic [3:0] S_DK_SLOT = 4'd4;
   localparam logic [3:0] S_DK_KEY  = 4'd5;
   localparam logic [3:0] S_UP      = 4'd6;
   localparam logic [3:0] S_UP_CMP  = 4'd7;
   localparam logic [3:0] S_DN      = 4'd8;
   localparam logic [3:0] S_DN_L    = 4'd9;
   localparam logic [3:0] S_DN_R    = 4'd10;
   localparam logic [3:0] S_DN_SEL  = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   logic [KEY_W-1:0] key_mem_ff [HEAP_DEPTH];
   logic [RW-1:0]    own_mem_ff [HEAP_DEPTH];
   logic [SW-1:0]    rs_mem_ff  [MAX_REQUESTS];

   logic [KEY_W-1:0] key_rd_ff;
   logic [RW-1:0]    own_rd_ff;
   logic [SW-1:0]    rs_rd_ff;

   logic [AW-1:0]    key_ra, key_wa;
   logic [RW-1:0]    rs_ra, rs_wa;
   logic             key_we, rs_we;
   logic [KEY_W-1:0] key_wd;
   logic [RW-1:0]    own_wd;
   logic [SW-1:0]    rs_wd;

   logic [3:0]       state_ff, state_in;
   req_word_type     req_ff, req_in;
   logic [SW-1:0]    count_ff, count_in;
   logic [RCW-1:0]   rcount_ff, rcount_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [KEY_W-1:0] cur_key_ff, cur_key_in;
   logic [RW-1:0]    cur_own_ff, cur_own_in;
   logic [KEY_W-1:0] ch_key_ff, ch_key_in;
   logic [RW-1:0]    ch_own_ff, ch_own_in;
   logic [AW-1:0]    ch_idx_ff, ch_idx_in;
   rsp_word_type     res_ff, res_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [KEY_W-1:0] alu_a, alu_b, alu_sat;
   logic             alu_lt;
   logic             accept;
   logic [AW-1:0]    parent;
   logic [LW-1:0]    left_w, right_w, count_w;
   logic [AW-1:0]    left_a, right_a;
   logic [SW-1:0]    last;

   imh_alu u_alu (
      .a        (alu_a),
      .b        (alu_b),
      .lt       (alu_lt),
      .sat_diff (alu_sat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign left_w  = {1'b0, pos_ff, 1'b1};
   assign right_w = left_w + LW'(1);
   assign count_w = LW'(count_ff);
   assign left_a  = left_w[AW-1:0];
   assign right_a = right_w[AW-1:0];
   assign last    = count_ff - SW'(1);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rcount_in    = rcount_ff;
      pos_in       = pos_ff;
      cur_key_in   = cur_key_ff;
      cur_own_in   = cur_own_ff;
      ch_key_in    = ch_key_ff;
      ch_own_in    = ch_own_ff;
      ch_idx_in    = ch_idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      key_ra       = '0;
      rs_ra        = '0;
      key_we       = 1'b0;
      key_wa       = pos_ff;
      key_wd       = cur_key_ff;
      own_wd       = cur_own_ff;
      rs_we        = 1'b0;
      rs_wa        = cur_own_ff;
      rs_wd        = SW'(pos_ff);
      alu_a        = cur_key_ff;
      alu_b        = key_rd_ff;

      case (state_ff)
         S_IDLE: begin
            rs_ra = RW'(CW'(req_word.request_id));
            if (accept) begin
               req_in = req_word;
               res_in = '{min_value: '0, min_valid: 1'b0, status: ST_OK};
               state_in = S_DONE;
               if (rcount_ff >= REQ_MAX) begin
                  res_in.status = ST_TABLE_FULL;
               end else begin
                  rcount_in = rcount_ff + RCW'(1);
                  rs_we     = 1'b1;
                  rs_wa     = rcount_ff[RW-1:0];
                  rs_wd     = NO_SLOT;
                  case (req_word.func)
                     FUNC_INSERT: begin
                        if (count_ff >= HEAP_MAX) begin
                           res_in.status = ST_FULL;
                        end else begin
                           cur_key_in = req_word.key_value ^ SIGN_FLIP;
                           cur_own_in = rcount_ff[RW-1:0];
                           pos_in     = count_ff[AW-1:0];
                           count_in   = count_ff + SW'(1);
                           state_in   = S_UP;
                        end
                     end
                     FUNC_GET_MIN: begin
                        if (count_ff == '0) res_in.status = ST_EMPTY;
                        else state_in = S_GM;
                     end
                     FUNC_EXTRACT: begin
                        if (count_ff == '0) res_in.status = ST_EMPTY;
                        else state_in = S_EX_OWN;
                     end
                     default: begin
                        if (CW'(req_word.request_id) >= CW'(rcount_ff))
                           res_in.status = ST_BAD_REQ;
                        else
                           state_in = S_DK_SLOT;
                     end
                  endcase
               end
            end
         end
         S_GM: begin
            res_in.min_value = key_rd_ff ^ SIGN_FLIP;
            res_in.min_valid = 1'b1;
            state_in         = S_DONE;
         end
         S_EX_OWN: begin
            rs_we    = 1'b1;
            rs_wa    = own_rd_ff;
            rs_wd    = NO_SLOT;
            count_in = last;
            key_ra   = last[AW-1:0];
            pos_in   = '0;
            state_in = (last == '0) ? S_DONE : S_EX_LAST;
         end
         S_EX_LAST: begin
            cur_key_in = key_rd_ff;
            cur_own_in = own_rd_ff;
            state_in   = S_DN;
         end
         S_DK_SLOT: begin
            key_ra = rs_rd_ff[AW-1:0];
            pos_in = rs_rd_ff[AW-1:0];
            if (rs_rd_ff >= count_ff) begin
               res_in.status = ST_BAD_REQ;
               state_in      = S_DONE;
            end else begin
               state_in = S_DK_KEY;
            end
         end
         S_DK_KEY: begin
            alu_a      = key_rd_ff;
            alu_b      = {1'b0, req_ff.delta};
            cur_key_in = alu_sat;
            cur_own_in = own_rd_ff;
            state_in   = S_UP;
         end
         S_UP: begin
            key_ra = parent;
            if (pos_ff == '0) begin
               key_we   = 1'b1;
               rs_we    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            key_we = 1'b1;
            rs_we  = 1'b1;
            if (alu_lt) begin
               key_wd   = key_rd_ff;
               own_wd   = own_rd_ff;
               rs_wa    = own_rd_ff;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN: begin
            key_ra = left_a;
            if (left_w >= count_w) begin
               key_we   = 1'b1;
               rs_we    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            key_ra    = right_a;
            ch_key_in = key_rd_ff;
            ch_own_in = own_rd_ff;
            ch_idx_in = left_a;
            state_in  = (right_w < count_w) ? S_DN_R : S_DN_SEL;
         end
         S_DN_R: begin
            alu_a = key_rd_ff;
            alu_b = ch_key_ff;
            if (alu_lt) begin
               ch_key_in = key_rd_ff;
               ch_own_in = own_rd_ff;
               ch_idx_in = right_a;
            end
            state_in = S_DN_SEL;
         end
         S_DN_SEL: begin
            alu_a  = ch_key_ff;
            alu_b  = cur_key_ff;
            key_we = 1'b1;
            rs_we  = 1'b1;
            if (alu_lt) begin
               key_wd   = ch_key_ff;
               own_wd   = ch_own_ff;
               rs_wa    = ch_own_ff;
               pos_in   = ch_idx_ff;
               state_in = S_DN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[key_wa] <= key_wd;
         own_mem_ff[key_wa] <= own_wd;
      end
      if (rs_we) begin
         rs_mem_ff[rs_wa] <= rs_wd;
      end
      key_rd_ff <= key_mem_ff[key_ra];
      own_rd_ff <= own_mem_ff[key_ra];
      rs_rd_ff  <= rs_mem_ff[rs_ra];
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      pos_ff     <= pos_in;
      cur_key_ff <= cur_key_in;
      cur_own_ff <= cur_own_in;
      ch_key_ff  <= ch_key_in;
      ch_own_ff  <= ch_own_in;
      ch_idx_ff  <= ch_idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
